FILE: hw/rtl/olt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants for the ordered list table engine
// Request/response structs, kind and status codes, cell command bundle.
// ----------------------------------------------------------------------------
package olt_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 6;

   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [2:0] {
      KIND_APPEND        = 3'd0,
      KIND_APPEND_UNIQUE = 3'd1,
      KIND_WRITE         = 3'd2,
      KIND_READ          = 3'd3,
      KIND_DELETE_AT     = 3'd4,
      KIND_DELETE_VALUE  = 3'd5,
      KIND_FIND          = 3'd6,
      KIND_CLEAR         = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      kind_type                   kind;
      logic [INDEX_W-1:0]         index;
      logic signed [WORD_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]   read_value;
      logic                       hit;
      logic [COUNT_W-1:0]         count;
      status_type                 status;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type                op;
      logic [IDX_W-1:0]           tgt;
      logic [WORD_W-1:0]          value;
      logic [COUNT_W-1:0]         count;
      logic [IDX_W-1:0]           rd_pos;
      logic                       rd_en;
   } cell_cmd_type;

endpackage

FILE: hw/rtl/olt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_cell: one slot of the list chain
// Holds one word, compares it against the broadcast key, takes the word of
// its upper neighbor on a shift.
// ----------------------------------------------------------------------------
module olt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [olt_pkg::IDX_W-1:0]     cell_pos,
   input  olt_pkg::cell_cmd_type         cmd,
   input  logic                          shift_sel,
   input  logic [olt_pkg::WORD_W-1:0]    upper_word,
   output logic [olt_pkg::WORD_W-1:0]    word,
   output logic                          match,
   output logic [olt_pkg::WORD_W-1:0]    rd_term
);

   logic [olt_pkg::WORD_W-1:0] word_ff, word_in;
   logic                       match_ff, match_in;
   logic [olt_pkg::WORD_W-1:0] rd_ff, rd_in;
   logic                       live;

   always_comb begin
      unique case (cmd.op)
         olt_pkg::CELL_HOLD:  word_in = word_ff;
         olt_pkg::CELL_LOAD:  word_in = (cell_pos == cmd.tgt) ? cmd.value : word_ff;
         olt_pkg::CELL_SHIFT: word_in = shift_sel ? upper_word : word_ff;
         olt_pkg::CELL_CLEAR: word_in = olt_pkg::EMPTY_WORD;
         default:             word_in = word_ff;
      endcase
   end

   assign live     = olt_pkg::COUNT_W'(cell_pos) < cmd.count;
   assign match_in = live && (word_ff == cmd.value);
   assign rd_in    = (cmd.rd_en && (cell_pos == cmd.rd_pos)) ? word_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= olt_pkg::EMPTY_WORD;
         match_ff <= 1'b0;
      end else begin
         word_ff  <= word_in;
         match_ff <= match_in;
      end
      rd_ff <= rd_in;
   end

   assign word    = word_ff;
   assign match   = match_ff;
   assign rd_term = rd_ff;

endmodule

FILE: hw/rtl/ordered_list_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_engine: packed list of signed words with shift delete
// Chain of slot cells with a small sequencer; one response per request.
// ----------------------------------------------------------------------------
// Sequence: each request passes the states idle (accept), match (cell
//   compare) and apply, where the response is registered; no new request
//   is taken until apply returns to idle. The compare stage in the cells
//   and the registered read terms set this sequence.
// A finished response may wait in its output register while the next
//   request is accepted; apply stalls only while that register holds a
//   response that the receiver is stalling.
// Reset: synchronous; all slots read -1 (empty), count 0, no response.
// ----------------------------------------------------------------------------
module ordered_list_table_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  olt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output olt_pkg::rsp_type  rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } state_type;

   state_type                         state_ff;
   olt_pkg::req_type                  req_ff;
   olt_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                              rsp_valid_ff;
   logic [olt_pkg::COUNT_W-1:0]       count_ff, count_in;

   olt_pkg::cell_cmd_type             cmd;
   logic [olt_pkg::DEPTH-1:0]         shift_mask;
   logic [olt_pkg::DEPTH-1:0]         match_vec;
   logic [olt_pkg::DEPTH-1:0]         first_ge;
   logic [olt_pkg::WORD_W-1:0]        words    [olt_pkg::DEPTH];
   logic [olt_pkg::WORD_W-1:0]        rd_terms [olt_pkg::DEPTH];
   logic [olt_pkg::WORD_W-1:0]        rd_or;

   logic apply_go;
   logic hit_any;
   logic index_ok;
   logic in_range;
   logic full;

   // ---- slot chain: cell k takes cell k+1's word on a delete shift --------
   for (genvar k = 0; k < olt_pkg::DEPTH; k++) begin : g_cell
      logic [olt_pkg::WORD_W-1:0] upper;
      if (k == olt_pkg::DEPTH - 1) begin : g_top
         assign upper = olt_pkg::EMPTY_WORD;    // refill the top slot
      end else begin : g_mid
         assign upper = words[k+1];
      end
      olt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_pos   (olt_pkg::IDX_W'(k)),
         .cmd        (cmd),
         .shift_sel  (shift_mask[k]),
         .upper_word (upper),
         .word       (words[k]),
         .match      (match_vec[k]),
         .rd_term    (rd_terms[k])
      );
   end

   // read terms are zero except at the addressed slot
   always_comb begin
      rd_or = '0;
      for (int k = 0; k < olt_pkg::DEPTH; k++) begin
         rd_or = rd_or | rd_terms[k];
      end
   end

   // mask of slots at or above the first match (all zero if no match)
   assign first_ge = match_vec | ~(match_vec - olt_pkg::DEPTH'(1));
   assign hit_any  = |match_vec;

   assign index_ok = 32'(req_ff.index) < olt_pkg::DEPTH;
   assign in_range = index_ok && (olt_pkg::COUNT_W'(req_ff.index) < count_ff);
   assign full     = count_ff == olt_pkg::COUNT_W'(olt_pkg::DEPTH);

   // apply waits only while an older response is still held
   assign apply_go = (state_ff == ST_APPLY) && !(rsp_valid_ff && rsp_stall);

   // ---- request decode: cell command, new count, response -----------------
   always_comb begin
      cmd.op     = olt_pkg::CELL_HOLD;
      cmd.tgt    = count_ff[olt_pkg::IDX_W-1:0];
      cmd.value  = req_ff.value;
      cmd.count  = count_ff;
      cmd.rd_pos = olt_pkg::IDX_W'(req_ff.index);
      cmd.rd_en  = index_ok;
      shift_mask = '0;
      count_in   = count_ff;
      rsp_in.read_value = '0;
      rsp_in.hit        = 1'b0;
      rsp_in.status     = olt_pkg::STATUS_OK;

      unique case (req_ff.kind)
         olt_pkg::KIND_APPEND: begin
            if (full) begin
               rsp_in.status = olt_pkg::STATUS_FULL;
            end else begin
               cmd.op   = olt_pkg::CELL_LOAD;
               count_in = count_ff + 1'b1;
            end
         end
         olt_pkg::KIND_APPEND_UNIQUE: begin
            if (hit_any) begin
               rsp_in.hit = 1'b1;
            end else if (full) begin
               rsp_in.status = olt_pkg::STATUS_FULL;
            end else begin
               cmd.op   = olt_pkg::CELL_LOAD;
               count_in = count_ff + 1'b1;
            end
         end
         olt_pkg::KIND_WRITE: begin
            // slots between count and index already hold -1
            if (!index_ok) begin
               rsp_in.status = olt_pkg::STATUS_RANGE;
            end else begin
               cmd.op  = olt_pkg::CELL_LOAD;
               cmd.tgt = olt_pkg::IDX_W'(req_ff.index);
               if (olt_pkg::COUNT_W'(req_ff.index) >= count_ff) begin
                  count_in = olt_pkg::COUNT_W'(req_ff.index) + 1'b1;
               end
            end
         end
         olt_pkg::KIND_READ: begin
            if (in_range) begin
               rsp_in.read_value = rd_or;
            end else begin
               rsp_in.status = olt_pkg::STATUS_RANGE;
            end
         end
         olt_pkg::KIND_DELETE_AT: begin
            if (in_range) begin
               cmd.op     = olt_pkg::CELL_SHIFT;
               shift_mask = {olt_pkg::DEPTH{1'b1}} << req_ff.index;
               count_in   = count_ff - 1'b1;
            end else begin
               rsp_in.status = olt_pkg::STATUS_RANGE;
            end
         end
         olt_pkg::KIND_DELETE_VALUE: begin
            if (hit_any) begin
               rsp_in.hit = 1'b1;
               cmd.op     = olt_pkg::CELL_SHIFT;
               shift_mask = first_ge;
               count_in   = count_ff - 1'b1;
            end
         end
         olt_pkg::KIND_FIND: begin
            rsp_in.hit = hit_any;
         end
         olt_pkg::KIND_CLEAR: begin
            cmd.op   = olt_pkg::CELL_CLEAR;
            count_in = '0;
         end
         default: begin
            cmd.op = olt_pkg::CELL_HOLD;
         end
      endcase

      if (!apply_go) begin
         cmd.op = olt_pkg::CELL_HOLD;
      end
      rsp_in.count = count_in;
   end

   // ---- sequencer: state, count and response register ---------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= ST_MATCH;
               end
            end
            ST_MATCH: begin
               // cells register match flags and the read term here
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (apply_go) begin
                  rsp_ff   <= rsp_in;
                  count_ff <= count_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // a new response replaces one that leaves at this edge
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ordered list table engine
// A directed table of requests, then 2000 random ones in phases that fill,
// drain, balance or scramble the list. Random idling on both channels. Every
// response is checked field by field against its pinned row or a shadow list.
// ----------------------------------------------------------------------------
module testbench;
   import olt_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 20;
   localparam int PHASE_LEN     = 100;
   localparam int DRAIN_CYCLES  = 12;   // headroom past the block latency

   // request mix of one random phase
   typedef enum int {
      MIX_BALANCED,
      MIX_FILL,
      MIX_DRAIN,
      MIX_NOISE
   } mix_type;

   // one row of the directed table; pinned rows carry a hand-written response
   typedef struct packed {
      req_type req;
      logic    pinned;
      rsp_type rsp;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow of the list: words at and above shadow_len always hold -1
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int                       shadow_len;
   rsp_type                  expected_rsp_q [$];
   stim_row_type             directed_rows [$];
   logic [WORD_W-1:0]        value_pool [16];
   logic                     sender_quiet = 1'b0;

   int errors        = 0;
   int accepted_reqs = 0;
   int checked_rsps  = 0;
   int hit_count     = 0;
   int full_count    = 0;
   int range_count   = 0;
   int cycle_count   = 0;

   ordered_list_table_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Shadow list
   // -------------------------------------------------------------------------

   // position of the first live word equal to v, -1 if absent
   function automatic int find_word(logic signed [WORD_W-1:0] v);
      for (int k = 0; k < shadow_len; k++)
         if (shadow_words[k] == v) return k;
      return -1;
   endfunction

   // remove one live word, close the hole, refill the vacated top slot
   function automatic void remove_word(int pos);
      for (int k = pos; k + 1 < shadow_len; k++)
         shadow_words[k] = shadow_words[k + 1];
      shadow_words[shadow_len - 1] = EMPTY_WORD;
      shadow_len--;
   endfunction

   function automatic void empty_list();
      for (int k = 0; k < DEPTH; k++)
         shadow_words[k] = EMPTY_WORD;
      shadow_len = 0;
   endfunction

   // applies one request to the shadow list and returns its response
   function automatic rsp_type apply_list_request(req_type r);
      rsp_type res;
      int      pos;
      int      idx;
      res        = '0;
      res.status = STATUS_OK;
      idx        = int'(r.index);
      case (r.kind)
         KIND_APPEND, KIND_APPEND_UNIQUE: begin
            pos = (r.kind == KIND_APPEND_UNIQUE) ? find_word(r.value) : -1;
            if (pos >= 0) begin
               res.hit = 1'b1;
            end else if (shadow_len >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_words[shadow_len] = r.value;
               shadow_len++;
            end
         end
         KIND_WRITE: begin
            if (idx >= DEPTH) begin
               res.status = STATUS_RANGE;
            end else begin
               // gap slots between the old count and idx read as empty
               for (int k = shadow_len; k < idx; k++)
                  shadow_words[k] = EMPTY_WORD;
               shadow_words[idx] = r.value;
               if (idx >= shadow_len) shadow_len = idx + 1;
            end
         end
         KIND_READ: begin
            if (idx >= shadow_len) res.status = STATUS_RANGE;
            else res.read_value = shadow_words[idx];
         end
         KIND_DELETE_AT: begin
            if (idx >= shadow_len) res.status = STATUS_RANGE;
            else remove_word(idx);
         end
         KIND_DELETE_VALUE: begin
            pos = find_word(r.value);
            if (pos >= 0) begin
               res.hit = 1'b1;
               remove_word(pos);
            end
         end
         KIND_FIND: begin
            res.hit = (find_word(r.value) >= 0);
         end
         default: begin
            empty_list();
         end
      endcase
      res.count = COUNT_W'(shadow_len);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   function automatic void add_row(kind_type kind, int idx, logic [WORD_W-1:0] value,
                                   logic pinned, logic [WORD_W-1:0] rd, logic hit,
                                   int cnt, status_type st);
      stim_row_type row;
      row.req.kind       = kind;
      row.req.index      = INDEX_W'(idx);
      row.req.value      = value;
      row.pinned         = pinned;
      row.rsp.read_value = rd;
      row.rsp.hit        = hit;
      row.rsp.count      = COUNT_W'(cnt);
      row.rsp.status     = st;
      directed_rows.push_back(row);
   endfunction

   // Walks the list from empty through full and back. Comments above the
   // groups of rows note what each group exercises.
   function automatic void load_directed_rows();
      // empty list: range errors, misses, nothing to delete
      add_row(KIND_READ,         0, 32'd0, 1, 32'd0, 0, 0, STATUS_RANGE);
      add_row(KIND_DELETE_AT,    0, 32'd0, 1, 32'd0, 0, 0, STATUS_RANGE);
      add_row(KIND_FIND,         0, 32'd5, 1, 32'd0, 0, 0, STATUS_OK);
      add_row(KIND_DELETE_VALUE, 0, 32'd5, 1, 32'd0, 0, 0, STATUS_OK);
      // word extremes: [max, min, -1]
      add_row(KIND_APPEND,        0, 32'h7FFF_FFFF, 1, 32'd0, 0, 1, STATUS_OK);
      add_row(KIND_APPEND,       63, 32'h8000_0000, 1, 32'd0, 0, 2, STATUS_OK);
      add_row(KIND_APPEND_UNIQUE, 0, 32'h7FFF_FFFF, 1, 32'd0, 1, 2, STATUS_OK);
      add_row(KIND_APPEND_UNIQUE, 0, 32'hFFFF_FFFF, 1, 32'd0, 0, 3, STATUS_OK);
      add_row(KIND_READ,          1, 32'd0, 1, 32'h8000_0000, 0, 3, STATUS_OK);
      // write past the count leaves empty gap slots 3..6
      add_row(KIND_WRITE,         7, 32'd123, 1, 32'd0, 0, 8, STATUS_OK);
      add_row(KIND_READ,          5, 32'd0, 1, 32'hFFFF_FFFF, 0, 8, STATUS_OK);
      add_row(KIND_FIND,          0, 32'hFFFF_FFFF, 1, 32'd0, 1, 8, STATUS_OK);
      // delete at the head shifts everything down
      add_row(KIND_DELETE_AT,     0, 32'd0, 1, 32'd0, 0, 7, STATUS_OK);
      add_row(KIND_READ,          0, 32'd0, 1, 32'h8000_0000, 0, 7, STATUS_OK);
      add_row(KIND_DELETE_VALUE,  0, 32'd123, 1, 32'd0, 1, 6, STATUS_OK);
      add_row(KIND_READ,          6, 32'd0, 1, 32'd0, 0, 6, STATUS_RANGE);
      // write the last slot: table full
      add_row(KIND_WRITE,        63, 32'd0, 1, 32'd0, 0, 64, STATUS_OK);
      add_row(KIND_APPEND,        0, 32'd1, 1, 32'd0, 0, 64, STATUS_FULL);
      add_row(KIND_APPEND_UNIQUE, 0, 32'd2, 1, 32'd0, 0, 64, STATUS_FULL);
      add_row(KIND_APPEND_UNIQUE, 0, 32'd0, 1, 32'd0, 1, 64, STATUS_OK);
      add_row(KIND_READ,         63, 32'd0, 1, 32'd0, 0, 64, STATUS_OK);
      // drop the top slot; a find of its old word must then miss
      add_row(KIND_DELETE_AT,    63, 32'd0, 1, 32'd0, 0, 63, STATUS_OK);
      add_row(KIND_FIND,          0, 32'd0, 0, 32'd0, 0, 0, STATUS_OK);
      add_row(KIND_CLEAR,         0, 32'd0, 1, 32'd0, 0, 0, STATUS_OK);
      add_row(KIND_READ,          0, 32'd0, 1, 32'd0, 0, 0, STATUS_RANGE);
   endfunction

   // Random request shaped by the phase mix. Values come mostly from a small
   // pool so duplicates, hits and deletes by value actually happen; indexes
   // mostly land on live entries or just past the count.
   function automatic req_type make_random_request(mix_type mix);
      req_type     r;
      int          roll;
      int          len;
      int unsigned edges [8];
      r.kind  = KIND_CLEAR;
      r.index = INDEX_W'($urandom_range(0, 63));
      r.value = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 15)] : $urandom;
      if (mix == MIX_NOISE) begin
         r.kind  = kind_type'($urandom_range(0, 7));
         r.value = $urandom;
         return r;
      end
      // cumulative weights in kind order, append first, clear last
      case (mix)
         MIX_FILL:  edges = '{40, 60, 75, 85, 89, 93, 99, 100};
         MIX_DRAIN: edges = '{10, 15, 20, 40, 65, 85, 97, 100};
         default:   edges = '{20, 35, 45, 60, 72, 84, 97, 100};
      endcase
      roll = $urandom_range(0, 99);
      for (int k = 7; k >= 0; k--)
         if (roll < edges[k]) r.kind = kind_type'(k);
      len = shadow_len;
      roll = $urandom_range(0, 9);
      if (r.kind == KIND_WRITE) begin
         if (roll < 4) begin
            r.index = INDEX_W'((len < DEPTH) ? len : DEPTH - 1);
         end else if (roll < 7 && len > 0) begin
            r.index = INDEX_W'($urandom_range(0, len - 1));
         end else if (roll < 9) begin
            r.index = INDEX_W'((len + 4 < DEPTH) ? len + $urandom_range(1, 4) : DEPTH - 1);
         end
      end else if (r.kind == KIND_READ || r.kind == KIND_DELETE_AT) begin
         if (roll < 9 && len > 0) r.index = INDEX_W'($urandom_range(0, len - 1));
      end
      return r;
   endfunction

   // Drives one request and waits for its handshake. The shadow list is
   // updated at the accepting edge, so later random choices see the exact
   // list contents. Valid is left high; the next call or the caller drops it.
   task automatic send_request(req_type r, logic pinned, rsp_type pinned_rsp);
      int      gap;
      rsp_type predicted;
      gap = sender_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_request(r);
      expected_rsp_q.push_back(pinned ? pinned_rsp : predicted);
      accepted_reqs++;
   endtask

   // stop sending until every outstanding response has come back
   task automatic hold_off_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      rsp_type no_rsp;
      mix_type mix;
      no_rsp = '0;
      empty_list();
      load_directed_rows();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].rsp);
      hold_off_until_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // first phase fills the list; noise stays a small share
         if (p == 0) mix = MIX_FILL;
         else if ($urandom_range(0, 9) == 0) mix = MIX_NOISE;
         else mix = mix_type'($urandom_range(0, 2));
         sender_quiet = ($urandom_range(0, 3) == 0);
         value_pool[0] = 32'h0000_0000;
         value_pool[1] = 32'hFFFF_FFFF;
         value_pool[2] = 32'h7FFF_FFFF;
         value_pool[3] = 32'h8000_0000;
         for (int k = 4; k < 16; k++)
            value_pool[k] = $urandom;
         if ($urandom_range(0, 4) == 0) hold_off_until_drained();
         repeat (PHASE_LEN) send_request(make_random_request(mix), 1'b0, no_rsp);
      end
      req_valid <= 1'b0;

      // let the pipe empty, then watch a little longer for stray responses
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d checked responses, %0d mismatches",
               accepted_reqs, checked_rsps, errors);
      $display("Responses with hit: %0d, table full: %0d, index out of range: %0d",
               hit_count, full_count, range_count);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: random stall before each response, with quiet stretches
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int   hold;
      int   served;
      logic quiet;
      served = 0;
      quiet  = 1'b0;
      @(negedge reset);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         served++;
         if (served % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Checker: each accepted response against the oldest expectation
   // -------------------------------------------------------------------------
   task automatic report_field(string field, logic [WORD_W-1:0] want,
                               logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rsp_q.pop_front();
            report_field("read_value", want.read_value, rsp_data.read_value);
            report_field("hit", want.hit, rsp_data.hit);
            report_field("count", want.count, rsp_data.count);
            report_field("status", want.status, rsp_data.status);
            checked_rsps++;
            if (want.hit) hit_count++;
            if (want.status == STATUS_FULL) full_count++;
            if (want.status == STATUS_RANGE) range_count++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsp_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
